// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Each macro expects clk and rst_n in scope and is idle while reset is applied.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== sv/chg_pkg.sv =====
package chg_pkg;

  // Core count and queue depth defaults, and the number of secondary core slots in a job.
  localparam int NUM_CORES_DEF   = 4;
  localparam int SEC_W           = 3;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Field widths.
  localparam int LOAD_W  = 16;
  localparam int MASK_W  = 4;
  localparam int RATE_W  = 22;
  localparam int CNT_W   = 8;
  localparam int CORE_W  = 2;
  localparam int NR_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [NR_W-1:0]   MAX_CORES_RST   = 3'd4;
  localparam logic [NR_W-1:0]   MIN_CORES_RST   = 3'd1;
  localparam logic [LOAD_W-1:0] LOAD_UP_RST     = 16'd25;
  localparam logic [LOAD_W-1:0] LOAD_DOWN_RST   = 16'd5;
  localparam logic [CNT_W-1:0]  TICKS_UP_RST    = 8'd1;
  localparam logic [CNT_W-1:0]  TICKS_DOWN_RST  = 8'd5;
  localparam logic [CNT_W-1:0]  CNT_SAT         = 8'hFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_CORES    = 3'd0,
    CFG_MIN_CORES    = 3'd1,
    CFG_LOAD_UP      = 3'd2,
    CFG_LOAD_DOWN    = 3'd3,
    CFG_TICKS_UP     = 3'd4,
    CFG_TICKS_DOWN   = 3'd5,
    CFG_SINGLE_OFF   = 3'd6
  } cfg_idx_t;

  // Request codes.
  typedef enum logic [2:0] {
    REQ_TICK    = 3'd0,
    REQ_SUSPEND = 3'd1,
    REQ_RESUME  = 3'd2,
    REQ_ENABLE  = 3'd3,
    REQ_DISABLE = 3'd4
  } req_t;

  // Action codes.
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_UP   = 2'd1,
    ACT_DOWN = 2'd2
  } act_t;

  // Input item.
  typedef struct packed {
    logic [2:0]        req_type;
    logic [LOAD_W-1:0] run_queue_load;
    logic [MASK_W-1:0] online_mask;
    logic [RATE_W-1:0] rate_core1;
    logic [RATE_W-1:0] rate_core2;
    logic [RATE_W-1:0] rate_core3;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [1:0]        action;
    logic [CORE_W-1:0] core_index;
    logic              last;
  } out_item_t;

  // Job handed from the front to the back: one action applied to every
  // secondary core whose bit is set (bit i is core i+1). No bits means no action.
  typedef struct packed {
    act_t             act;
    logic [SEC_W-1:0] cores;
  } job_t;

endpackage

// ===== sv/core_hotplug_governor.sv =====
// Core hotplug governor. Requests (tick, suspend, resume, enable, disable) enter through a
// queue-style push port and each gives one to three results on the pop side, the final one
// marked last. A request is accepted in any cycle in which the internal job queue has room;
// the front stage decides the whole action in that cycle. The back stage then produces one
// result per cycle while the pop side keeps taking results, so a request occupies it for
// one to three results, and that single output register sets the sustained rate. Configuration
// writes take effect at once and are meant to be made only while the block is idle.
module core_hotplug_governor import chg_pkg::*; #(
  parameter int NUM_CORES   = NUM_CORES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  in_item_t              in_item,
  output logic                  in_full,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic job_push;
  logic job_full;
  job_t job_in;
  job_t head_job;
  logic head_valid;
  logic job_pop;

  // Front: accepts and classifies requests, owns governor state and registers.
  chg_front #(
    .NUM_CORES(NUM_CORES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .job_push  (job_push),
    .job       (job_in),
    .job_full  (job_full)
  );

  // Job queue between the two stages.
  chg_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_job   (job_in),
    .full       (job_full),
    .pop        (job_pop),
    .head_job   (head_job),
    .head_valid (head_valid)
  );

  // Back: expands each job into per-core results.
  chg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_job   (head_job),
    .head_valid (head_valid),
    .job_pop    (job_pop),
    .out_item   (out_item),
    .out_empty  (out_empty),
    .out_pop    (out_pop)
  );

endmodule

// ===== sv/chg_queue.sv =====
`include "assert_macros.svh"

module chg_queue import chg_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head_job,
  output logic head_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

  job_t               mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]  count_r, count_nxt;
  logic               do_push, do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_job   = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update, wrapping at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  // The fill count tracks the pointer distance.
  `ASSERT_CLK(a_q_count, (count_r <= CNT_FULL) && ((count_r == '0 || count_r == CNT_FULL) -> (wr_ptr_r == rd_ptr_r)), "queue count and pointers disagree")

endmodule

// ===== sv/chg_front.sv =====
`include "assert_macros.svh"

module chg_front import chg_pkg::*; #(
  parameter int NUM_CORES = NUM_CORES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  in_item_t              in_item,
  output logic                  in_full,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  job_push,
  output job_t                  job,
  input  logic                  job_full
);

  // Configuration registers.
  logic [NR_W-1:0]   max_cores_r;
  logic [NR_W-1:0]   min_cores_r;
  logic [LOAD_W-1:0] load_up_r;
  logic [LOAD_W-1:0] load_down_r;
  logic [CNT_W-1:0]  ticks_up_r;
  logic [CNT_W-1:0]  ticks_down_r;
  logic              single_off_r;

  // Governor state.
  logic [CNT_W-1:0]  cycle_count_r, cycle_count_nxt;
  logic              enabled_r, enabled_nxt;
  logic              ticking_r, ticking_nxt;

  logic              accept;
  logic [MASK_W-1:0] mask_eff;
  logic [NR_W-1:0]   nr_online;
  logic [SEC_W-1:0]  sec_online;
  logic [SEC_W-1:0]  sec_offline;
  logic [SEC_W-1:0]  first_off;
  logic [SEC_W-1:0]  slow_sel;
  logic              slow_found;
  logic [RATE_W-1:0] min_rate;
  logic [RATE_W-1:0] rates [SEC_W];
  logic [CNT_W-1:0]  count_inc;

  assign in_full  = job_full;
  assign accept   = in_push && !job_full;
  assign job_push = accept;

  assign rates[0] = in_item.rate_core1;
  assign rates[1] = in_item.rate_core2;
  assign rates[2] = in_item.rate_core3;

  // Effective mask: core zero always online, cores beyond the count ignored.
  always_comb begin
    mask_eff  = '0;
    nr_online = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (i < NUM_CORES) begin
        mask_eff[i] = (i == 0) ? 1'b1 : in_item.online_mask[i];
      end
    end
    for (int i = 0; i < MASK_W; i++) begin
      nr_online = nr_online + NR_W'(mask_eff[i]);
    end
  end

  // Secondary core views: online, offline, lowest offline and slowest online.
  always_comb begin
    sec_online  = '0;
    sec_offline = '0;
    first_off   = '0;
    slow_sel    = '0;
    slow_found  = 1'b0;
    min_rate    = '0;
    for (int i = 0; i < SEC_W; i++) begin
      if (i + 1 < NUM_CORES) begin
        sec_online[i]  = mask_eff[i + 1];
        sec_offline[i] = !mask_eff[i + 1];
      end
    end
    for (int i = SEC_W - 1; i >= 0; i--) begin
      if (sec_offline[i]) begin
        first_off    = '0;
        first_off[i] = 1'b1;
      end
    end
    for (int i = 0; i < SEC_W; i++) begin
      if (sec_online[i] && (!slow_found || rates[i] < min_rate)) begin
        slow_found  = 1'b1;
        min_rate    = rates[i];
        slow_sel    = '0;
        slow_sel[i] = 1'b1;
      end
    end
  end

  assign count_inc = (cycle_count_r == CNT_SAT) ? cycle_count_r : cycle_count_r + 1'b1;

  // Classify the request into a job and work out the next governor state.
  always_comb begin
    cycle_count_nxt = cycle_count_r;
    enabled_nxt     = enabled_r;
    ticking_nxt     = ticking_r;
    job.act         = ACT_NONE;
    job.cores       = '0;
    case (req_t'(in_item.req_type))
      REQ_TICK: begin
        if (ticking_r) begin
          cycle_count_nxt = count_inc;
          if (nr_online < max_cores_r && in_item.run_queue_load >= load_up_r) begin
            if (count_inc >= ticks_up_r) begin
              job.act         = ACT_UP;
              job.cores       = first_off;
              cycle_count_nxt = '0;
            end
          end else if (nr_online > min_cores_r && in_item.run_queue_load <= load_down_r) begin
            if (count_inc >= ticks_down_r) begin
              job.act         = ACT_DOWN;
              job.cores       = slow_sel;
              cycle_count_nxt = '0;
            end
          end
        end
      end
      REQ_SUSPEND: begin
        if (single_off_r) begin
          job.act   = ACT_DOWN;
          job.cores = sec_online;
        end
        ticking_nxt = 1'b0;
      end
      REQ_RESUME: begin
        if (single_off_r) begin
          job.act   = ACT_UP;
          job.cores = sec_offline;
        end
        ticking_nxt = enabled_r;
      end
      REQ_ENABLE: begin
        enabled_nxt = 1'b1;
        ticking_nxt = 1'b1;
      end
      REQ_DISABLE: begin
        enabled_nxt = 1'b0;
        ticking_nxt = 1'b0;
        job.act     = ACT_UP;
        job.cores   = sec_offline;
      end
      default: begin
        job.act = ACT_NONE;
      end
    endcase
  end

  // Governor state advances on each accepted transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_count_r <= '0;
      enabled_r     <= 1'b1;
      ticking_r     <= 1'b1;
    end else if (accept) begin
      cycle_count_r <= cycle_count_nxt;
      enabled_r     <= enabled_nxt;
      ticking_r     <= ticking_nxt;
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cores_r  <= MAX_CORES_RST;
      min_cores_r  <= MIN_CORES_RST;
      load_up_r    <= LOAD_UP_RST;
      load_down_r  <= LOAD_DOWN_RST;
      ticks_up_r   <= TICKS_UP_RST;
      ticks_down_r <= TICKS_DOWN_RST;
      single_off_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAX_CORES:  max_cores_r  <= cfg_wdata[NR_W-1:0];
        CFG_MIN_CORES:  min_cores_r  <= cfg_wdata[NR_W-1:0];
        CFG_LOAD_UP:    load_up_r    <= cfg_wdata[LOAD_W-1:0];
        CFG_LOAD_DOWN:  load_down_r  <= cfg_wdata[LOAD_W-1:0];
        CFG_TICKS_UP:   ticks_up_r   <= cfg_wdata[CNT_W-1:0];
        CFG_TICKS_DOWN: ticks_down_r <= cfg_wdata[CNT_W-1:0];
        CFG_SINGLE_OFF: single_off_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Ticks stay off after a disable until an enable comes.
  `ASSERT_CLK(a_fe_disable, (accept && in_item.req_type == REQ_DISABLE) |=> (!ticking_r && !enabled_r), "disable did not stop ticks")

endmodule

// ===== sv/chg_back.sv =====
`include "assert_macros.svh"

module chg_back import chg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      head_job,
  input  logic      head_valid,
  output logic      job_pop,
  output out_item_t out_item,
  output logic      out_empty,
  input  logic      out_pop
);

  act_t             act_r, act_nxt;
  logic [SEC_W-1:0] rem_r, rem_nxt;
  logic             busy_r, busy_nxt;
  out_item_t        res_r, res_nxt;
  logic             res_valid_r, res_valid_nxt;

  logic             taken;
  logic             emit;
  logic             finish;
  logic             load;
  logic [SEC_W-1:0] low_bit;
  logic [CORE_W-1:0] low_core;
  logic [SEC_W-1:0] rem_after;

  assign out_item  = res_r;
  assign out_empty = !res_valid_r;
  assign taken     = out_pop && res_valid_r;

  // Lowest remaining core of the current job.
  always_comb begin
    low_bit  = '0;
    low_core = '0;
    for (int i = SEC_W - 1; i >= 0; i--) begin
      if (rem_r[i]) begin
        low_bit    = '0;
        low_bit[i] = 1'b1;
        low_core   = CORE_W'(i + 1);
      end
    end
  end

  assign rem_after = rem_r & ~low_bit;
  assign emit      = busy_r && (!res_valid_r || taken);
  assign finish    = emit && (rem_after == '0);
  assign load      = head_valid && (!busy_r || finish);
  assign job_pop   = load;

  // Walk the job one core per result; an empty job gives one no-action result.
  always_comb begin
    act_nxt       = act_r;
    rem_nxt       = rem_r;
    busy_nxt      = busy_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r;
    if (taken) begin
      res_valid_nxt = 1'b0;
    end
    if (emit) begin
      res_valid_nxt = 1'b1;
      res_nxt.last  = (rem_after == '0);
      if (rem_r == '0) begin
        res_nxt.action     = ACT_NONE;
        res_nxt.core_index = '0;
      end else begin
        res_nxt.action     = act_r;
        res_nxt.core_index = low_core;
      end
      rem_nxt = rem_after;
      if (finish) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      act_nxt  = head_job.act;
      rem_nxt  = head_job.cores;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
  end

  // A no-action result names core zero and closes its item.
  `ASSERT_CLK(a_be_none, (res_valid_r && res_r.action == ACT_NONE) |-> (res_r.core_index == '0 && res_r.last), "no-action result malformed")
  // A waiting result is never overwritten.
  `ASSERT_NEVER(a_be_overrun, emit && res_valid_r && !taken, "result overwritten before transfer")

endmodule
